[design/scanline_line_buffer_unit_assert.svh]
// Assertion macros shared by the line buffer modules.
// Each use expects clk and arst_n to be visible in the module.
`ifndef SCANLINE_LINE_BUFFER_UNIT_ASSERT_SVH
`define SCANLINE_LINE_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SLB_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line buffer assertion failed");

// Next-cycle implication, disabled during reset
`define SLB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line buffer assertion failed");

`endif

[design/slb_pkg.sv]
// ----------------------------------------------------------------------------
// slb_pkg
// Types, constants and helper functions of the scanline line buffer.
// ----------------------------------------------------------------------------
package slb_pkg;

	// Line geometry: cells are spread over four banks by position modulo 4
	localparam int LINE_CELLS = 160;
	localparam int LANES      = 4;
	localparam int BANK_DEPTH = (LINE_CELLS + LANES - 1) / LANES;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam logic [8:0] LINE_END = 9'(LINE_CELLS);

	localparam int CELL_W   = 5;
	localparam int COLOUR_W = 8;
	localparam int CTAB_DEPTH = 32;
	localparam int CTAB_AW    = 5;

	// Request types
	localparam logic [2:0] REQ_CLEAR  = 3'd0;
	localparam logic [2:0] REQ_START  = 3'd1;
	localparam logic [2:0] REQ_STORE  = 3'd2;
	localparam logic [2:0] REQ_READ   = 3'd3;
	localparam logic [2:0] REQ_COLOUR = 3'd4;

	// Configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_KANGAROO  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_MODE = 4'd1;

	// Read modes
	localparam logic [1:0] RM_WIDE    = 2'd0;
	localparam logic [1:0] RM_NONE    = 2'd1;
	localparam logic [1:0] RM_HIRES_A = 2'd2;
	localparam logic [1:0] RM_HIRES_B = 2'd3;

	// Store control broadcast to every lane
	typedef struct packed {
		logic       active;
		logic [7:0] pos;
		logic       wmode;
		logic [7:0] data;
		logic       hole;
		logic [2:0] pal;
		logic       kangaroo;
	} store_ctrl_t;

	// Colour table addresses of the two pixels of a cell
	typedef struct packed {
		logic [CTAB_AW-1:0] left;
		logic [CTAB_AW-1:0] right;
	} pix_addr_t;

	// Codes with a zero colour part read the background entry
	function automatic logic [CTAB_AW-1:0] look_up(input logic [CELL_W-1:0] code);
		look_up = (code[1:0] != 2'b00) ? code : '0;
	endfunction

endpackage

[design/slb_req_if.sv]
// ----------------------------------------------------------------------------
// slb_req_if
// Request channel of the line buffer: valid, ready and the request fields.
// ----------------------------------------------------------------------------
interface slb_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [7:0]  position;
	logic [2:0]  palette_number;
	logic        write_mode;
	logic [7:0]  graphic_byte;
	logic [15:0] fetch_address;
	logic        holey_8;
	logic        holey_16;
	logic [7:0]  cell_index;
	logic [4:0]  color_index;
	logic [7:0]  color_value;

	modport source (
		output valid, req_type, position, palette_number, write_mode, graphic_byte,
			fetch_address, holey_8, holey_16, cell_index, color_index, color_value,
		input  ready
	);
	modport sink (
		input  valid, req_type, position, palette_number, write_mode, graphic_byte,
			fetch_address, holey_8, holey_16, cell_index, color_index, color_value,
		output ready
	);
endinterface

[design/slb_resp_if.sv]
// ----------------------------------------------------------------------------
// slb_resp_if
// Pixel result channel of the line buffer: valid, ready and two colours.
// ----------------------------------------------------------------------------
interface slb_resp_if;
	logic       valid;
	logic       ready;
	logic [7:0] left_color;
	logic [7:0] right_color;
	logic       pixels_valid;

	modport source (
		output valid, left_color, right_color, pixels_valid,
		input  ready
	);
	modport sink (
		input  valid, left_color, right_color, pixels_valid,
		output ready
	);
endinterface

[design/slb_cfg_if.sv]
// ----------------------------------------------------------------------------
// slb_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
interface slb_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [slb_pkg::CFG_IDX_W-1:0]   reg_index;
	logic [slb_pkg::CFG_DAT_W-1:0]   write_data;

	modport source (output valid, reg_index, write_data, input ready);
	modport sink   (input valid, reg_index, write_data, output ready);
endinterface

[design/slb_ram.sv]
// ----------------------------------------------------------------------------
// slb_ram
// Generic one-write, one-read RAM with registered read data (read-first).
// ----------------------------------------------------------------------------
module slb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and read; a read at the write address returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/slb_lane.sv]
// ----------------------------------------------------------------------------
// slb_lane
// One cell bank of the line: takes the cell of a stored byte that falls on
// this bank, holds its valid bits, and reads one cell out.
// ----------------------------------------------------------------------------
`include "scanline_line_buffer_unit_assert.svh"

module slb_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    lane_id,
	input  slb_pkg::store_ctrl_t          store,
	input  logic                          clr,
	input  logic                          rd_en,
	input  logic [slb_pkg::BANK_AW-1:0]   rd_addr,
	output logic [slb_pkg::CELL_W-1:0]    cell_out
);

	logic [1:0]                     k;
	logic [7:0]                     cpos;
	logic [5:0]                     cword;
	logic                           in_line;
	logic                           used;
	logic [1:0]                     colour2;
	logic [3:0]                     nib;
	logic [slb_pkg::CELL_W-1:0]     code;
	logic                           empty;
	logic                           we;
	logic [slb_pkg::CELL_W-1:0]     wdata;
	logic [slb_pkg::BANK_AW-1:0]    waddr;
	logic [slb_pkg::BANK_DEPTH-1:0] valid_q;
	logic                           rd_valid_q;
	logic [slb_pkg::CELL_W-1:0]     ram_data;

	// Work out which cell of the byte lands on this bank
	always_comb begin
		k       = lane_id - store.pos[1:0];
		cpos    = store.pos + {6'd0, k};
		cword   = cpos[7:2];
		waddr   = cword[slb_pkg::BANK_AW-1:0];
		in_line = ({1'b0, cpos} < slb_pkg::LINE_END);
		used    = store.wmode ? (k[1] == 1'b0) : 1'b1;
	end

	// Pick the cell code for this bank
	always_comb begin
		case (k)
			2'd0:    colour2 = store.data[7:6];
			2'd1:    colour2 = store.data[5:4];
			2'd2:    colour2 = store.data[3:2];
			default: colour2 = store.data[1:0];
		endcase
		nib = k[0] ? {store.data[1:0], store.data[5:4]}
			: {store.data[3:2], store.data[7:6]};
		if (store.wmode) begin
			code  = {store.pal[2], nib};
			empty = (nib == 4'd0) || store.hole;
		end else begin
			code  = {store.pal, colour2};
			empty = (colour2 == 2'd0) || store.hole;
		end
	end

	// Empty cells only overwrite in kangaroo mode
	assign we    = store.active && used && in_line && (!empty || store.kangaroo);
	assign wdata = empty ? '0 : code;

	slb_ram #(
		.WIDTH (slb_pkg::CELL_W),
		.DEPTH (slb_pkg::BANK_DEPTH)
	) u_bank (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_data)
	);

	// Valid bits: drop all on clear, mark on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Sample the valid bit alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else if (rd_en) begin
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign cell_out = rd_valid_q ? ram_data : '0;

	`SLB_ASSERT_IMPLY(a_hole_no_write, store.active && store.hole && !store.kangaroo, !we)
	`SLB_ASSERT_IMPLY(a_plain_write_nonzero, we && !store.kangaroo, wdata != '0)
	`SLB_ASSERT_NEXT(a_clear_drops_all, clr, valid_q == '0)

endmodule

[design/slb_decode.sv]
// ----------------------------------------------------------------------------
// slb_decode
// Merge step of a cell read: turns the selected cell into the colour table
// addresses of its two pixels according to the read mode.
// ----------------------------------------------------------------------------
module slb_decode (
	input  logic [slb_pkg::CELL_W-1:0] cell_code,
	input  logic [1:0]                 read_mode,
	output slb_pkg::pix_addr_t         addr
);

	logic [slb_pkg::CELL_W-1:0] l_code;
	logic [slb_pkg::CELL_W-1:0] r_code;

	// Split the cell into the two pixel codes
	always_comb begin
		case (read_mode)
			slb_pkg::RM_WIDE: begin
				l_code = cell_code;
				r_code = cell_code;
			end
			slb_pkg::RM_HIRES_A: begin
				l_code = {cell_code[4], 2'b00, cell_code[1], cell_code[3]};
				r_code = {cell_code[4], 2'b00, cell_code[0], cell_code[2]};
			end
			slb_pkg::RM_HIRES_B: begin
				l_code = {cell_code[4:1], 1'b0};
				r_code = {cell_code[4:2], cell_code[0], 1'b0};
			end
			default: begin
				l_code = '0;
				r_code = '0;
			end
		endcase
		addr.left  = slb_pkg::look_up(l_code);
		addr.right = slb_pkg::look_up(r_code);
	end

endmodule

[design/scanline_line_buffer_unit.sv]
// ----------------------------------------------------------------------------
// scanline_line_buffer_unit
// Line buffer of 5-bit cells with a 32-entry colour table.
//
//   channel | dir | carries
//   --------+-----+------------------------------------------------
//   req     | in  | clear, start object, store byte, read, colour
//   resp    | out | left_color, right_color, pixels_valid
//   cfg     | in  | reg_index, write_data (kangaroo, read mode)
//
// One item per cycle while req.ready is high. A store writes its two or
// four cells together, one per bank lane; clear line drops all per-cell valid
// bits at once. A read passes the bank RAM read, then the colour RAM read.
// A read waits in stage one while the output register is full and not taken;
// only then does req.ready fall. Other items go on while a result waits.
// Reset clears all control state and valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "scanline_line_buffer_unit_assert.svh"

module scanline_line_buffer_unit (
	input  logic        clk,
	input  logic        arst_n,
	slb_req_if.sink     req,
	slb_resp_if.source  resp,
	slb_cfg_if.sink     cfg
);

	logic                          accept;
	logic                          is_read;
	logic                          out_free;
	logic                          s1_move;
	logic                          rd_in_line;
	logic                          rd_en;
	logic [5:0]                    rd_word;
	logic [slb_pkg::BANK_AW-1:0]   rd_addr;
	logic                          hole;
	logic                          colour_we;
	logic                          store_acc;
	logic [7:0]                    pos_adv;
	logic                          pix_zero;

	logic                          kangaroo_q;
	logic [1:0]                    read_mode_q;
	logic [7:0]                    cell_position_q;
	logic [2:0]                    object_palette_q;
	logic                          object_wmode_q;
	logic [slb_pkg::CTAB_DEPTH-1:0] ctab_valid_q;

	logic                          s1_v_q;
	logic [1:0]                    lane_sel_s1;
	logic                          in_line_s1;
	logic                          out_v_q;
	logic                          pix_valid_s2;
	logic                          left_set_s2;
	logic                          right_set_s2;

	slb_pkg::store_ctrl_t          store;
	logic [slb_pkg::CELL_W-1:0]    lane_cell [slb_pkg::LANES];
	logic [slb_pkg::CELL_W-1:0]    sel_cell;
	slb_pkg::pix_addr_t            pix_addr;
	logic [slb_pkg::COLOUR_W-1:0]  left_data;
	logic [slb_pkg::COLOUR_W-1:0]  right_data;

	// Handshake
	assign out_free  = !out_v_q || resp.ready;
	assign s1_move   = s1_v_q && out_free;
	assign req.ready = !s1_v_q || out_free;
	assign accept    = req.valid && req.ready;
	assign is_read   = (req.req_type == slb_pkg::REQ_READ);
	assign cfg.ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kangaroo_q  <= 1'b0;
			read_mode_q <= slb_pkg::RM_WIDE;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				slb_pkg::CFG_KANGAROO:  kangaroo_q  <= cfg.write_data[0];
				slb_pkg::CFG_READ_MODE: read_mode_q <= cfg.write_data[1:0];
				default: ;
			endcase
		end
	end

	// Object state: set on start, advance on store
	assign store_acc = accept && (req.req_type == slb_pkg::REQ_STORE);
	assign pos_adv   = cell_position_q + (object_wmode_q ? 8'd2 : 8'd4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_position_q  <= '0;
			object_palette_q <= '0;
			object_wmode_q   <= 1'b0;
		end else if (accept && (req.req_type == slb_pkg::REQ_START)) begin
			cell_position_q  <= req.position;
			object_palette_q <= req.palette_number;
			object_wmode_q   <= req.write_mode;
		end else if (store_acc) begin
			cell_position_q  <= pos_adv;
		end
	end

	// Holey fetch test
	assign hole = req.fetch_address[15] &&
		((req.holey_16 && req.fetch_address[12]) || (req.holey_8 && req.fetch_address[11]));

	always_comb begin
		store.active   = store_acc;
		store.pos      = cell_position_q;
		store.wmode    = object_wmode_q;
		store.data     = req.graphic_byte;
		store.hole     = hole;
		store.pal      = object_palette_q;
		store.kangaroo = kangaroo_q;
	end

	// Read address into the banks
	assign rd_in_line = ({1'b0, req.cell_index} < slb_pkg::LINE_END);
	assign rd_word    = req.cell_index[7:2];
	assign rd_addr    = rd_word[slb_pkg::BANK_AW-1:0];
	assign rd_en      = accept && is_read && rd_in_line;

	// Bank lanes
	for (genvar g = 0; g < slb_pkg::LANES; g++) begin : g_lane
		slb_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.lane_id  (2'(g)),
			.store    (store),
			.clr      (accept && (req.req_type == slb_pkg::REQ_CLEAR)),
			.rd_en    (rd_en && (req.cell_index[1:0] == 2'(g))),
			.rd_addr  (rd_addr),
			.cell_out (lane_cell[g])
		);
	end

	// Stage one: bank read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= is_read;
		end else if (s1_move) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_read) begin
			lane_sel_s1 <= req.cell_index[1:0];
			in_line_s1  <= rd_in_line;
		end
	end

	// Merge the lanes: select the addressed bank and decode the pixels
	assign sel_cell = in_line_s1 ? lane_cell[lane_sel_s1] : '0;

	slb_decode u_decode (
		.cell_code (sel_cell),
		.read_mode (read_mode_q),
		.addr      (pix_addr)
	);

	// Colour table, one copy for each pixel
	assign colour_we = accept && (req.req_type == slb_pkg::REQ_COLOUR);

	slb_ram #(
		.WIDTH (slb_pkg::COLOUR_W),
		.DEPTH (slb_pkg::CTAB_DEPTH)
	) u_ctab_left (
		.clk   (clk),
		.we    (colour_we),
		.waddr (req.color_index),
		.wdata (req.color_value),
		.re    (s1_move),
		.raddr (pix_addr.left),
		.rdata (left_data)
	);

	slb_ram #(
		.WIDTH (slb_pkg::COLOUR_W),
		.DEPTH (slb_pkg::CTAB_DEPTH)
	) u_ctab_right (
		.clk   (clk),
		.we    (colour_we),
		.waddr (req.color_index),
		.wdata (req.color_value),
		.re    (s1_move),
		.raddr (pix_addr.right),
		.rdata (right_data)
	);

	// Colour valid bits: entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctab_valid_q <= '0;
		end else if (colour_we) begin
			ctab_valid_q[req.color_index] <= 1'b1;
		end
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_move) begin
			out_v_q <= 1'b1;
		end else if (resp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			pix_valid_s2 <= (read_mode_q != slb_pkg::RM_NONE);
			left_set_s2  <= ctab_valid_q[pix_addr.left];
			right_set_s2 <= ctab_valid_q[pix_addr.right];
		end
	end

	assign resp.valid        = out_v_q;
	assign resp.pixels_valid = pix_valid_s2;
	assign resp.left_color   = (pix_valid_s2 && left_set_s2) ? left_data : '0;
	assign resp.right_color  = (pix_valid_s2 && right_set_s2) ? right_data : '0;
	assign pix_zero          = (resp.left_color == '0) && (resp.right_color == '0);

	`SLB_ASSERT_NEXT(a_s1_fills_output, s1_move, out_v_q)
	`SLB_ASSERT_IMPLY(a_no_pixels_zero, out_v_q && !pix_valid_s2, pix_zero)
	`SLB_ASSERT_NEXT(a_store_advances, store_acc, cell_position_q == $past(pos_adv))

endmodule

[dv/slb_pixel_checker.sv]
// ----------------------------------------------------------------------------
// slb_pixel_checker
// Watches the request, configuration and pixel channels of the line buffer.
// Keeps its own copy of the line, the colour table and the object state,
// works out the pixel pair of every accepted read and compares each pixel
// item taken from the block with the oldest pair still owed.
// ----------------------------------------------------------------------------
module slb_pixel_checker (
	input  logic clk,
	input  logic arst_n,
	slb_req_if   req,
	slb_resp_if  resp,
	slb_cfg_if   cfg,
	output int   mismatches,
	output int   outstanding
);

	typedef struct packed {
		logic [slb_pkg::COLOUR_W-1:0] left;
		logic [slb_pkg::COLOUR_W-1:0] right;
		logic                         shown;
	} pixel_pair_t;

	logic [slb_pkg::CELL_W-1:0]   line_model   [slb_pkg::LINE_CELLS];
	logic [slb_pkg::COLOUR_W-1:0] colour_model [slb_pkg::CTAB_DEPTH];
	logic [7:0]                   draw_pos;
	logic [2:0]                   draw_pal;
	logic                         draw_two;
	logic                         kangaroo;
	logic [1:0]                   rd_mode;
	pixel_pair_t                  owed_pixels [$];
	pixel_pair_t                  want;

	// Lay one cell at the draw position; drop it past the line end
	function automatic void lay_cell(input logic [slb_pkg::CELL_W-1:0] code,
			input logic empty);
		if (draw_pos < slb_pkg::LINE_CELLS) begin
			if (!empty)
				line_model[draw_pos] = code;
			else if (kangaroo)
				line_model[draw_pos] = '0;
		end
		draw_pos = draw_pos + 8'd1;
	endfunction

	// Spread one graphic byte over two or four cells
	function automatic void store_graphic(input logic [7:0] data, input logic [15:0] addr,
			input logic h8, input logic h16);
		logic       hole;
		logic [3:0] a;
		logic [3:0] b;
		logic [1:0] c;
		int         s;
		hole = addr[15] && ((h16 && addr[12]) || (h8 && addr[11]));
		if (draw_two) begin
			a = hole ? 4'd0 : {data[3:2], data[7:6]};
			b = hole ? 4'd0 : {data[1:0], data[5:4]};
			lay_cell({draw_pal[2], a}, a == 4'd0);
			lay_cell({draw_pal[2], b}, b == 4'd0);
		end else begin
			for (s = 6; s >= 0; s -= 2) begin
				c = hole ? 2'd0 : data[s +: 2];
				lay_cell({draw_pal, c}, c == 2'd0);
			end
		end
	endfunction

	// Codes with no colour bits show the background entry
	function automatic logic [slb_pkg::COLOUR_W-1:0] colour_of(
			input logic [slb_pkg::CELL_W-1:0] code);
		return (code[1:0] != 2'b00) ? colour_model[code] : colour_model[0];
	endfunction

	function automatic pixel_pair_t predict_pixels(input logic [7:0] idx);
		logic [slb_pkg::CELL_W-1:0] c;
		pixel_pair_t                p;
		c = (idx < slb_pkg::LINE_CELLS) ? line_model[idx] : '0;
		p.shown = 1'b1;
		case (rd_mode)
			slb_pkg::RM_WIDE: begin
				p.left  = colour_of(c);
				p.right = p.left;
			end
			slb_pkg::RM_HIRES_A: begin
				p.left  = colour_of({c[4], 2'b00, c[1], c[3]});
				p.right = colour_of({c[4], 2'b00, c[0], c[2]});
			end
			slb_pkg::RM_HIRES_B: begin
				p.left  = colour_of({c[4:1], 1'b0});
				p.right = colour_of({c[4:2], c[0], 1'b0});
			end
			default: begin
				p.left  = '0;
				p.right = '0;
				p.shown = 1'b0;
			end
		endcase
		return p;
	endfunction

	function automatic void flag(input string what, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
		mismatches++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (line_model[i])
				line_model[i] = '0;
			foreach (colour_model[i])
				colour_model[i] = '0;
			draw_pos  = '0;
			draw_pal  = '0;
			draw_two  = 1'b0;
			kangaroo  = 1'b0;
			rd_mode   = slb_pkg::RM_WIDE;
			owed_pixels.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			// Track register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					slb_pkg::CFG_KANGAROO:  kangaroo = cfg.write_data[0];
					slb_pkg::CFG_READ_MODE: rd_mode  = cfg.write_data[1:0];
					default: ;
				endcase
			end

			// Compare each pixel item with the oldest pair owed
			if (resp.valid && resp.ready) begin
				if (owed_pixels.size() == 0) begin
					$display("%0t: unexpected pixel item, expected none, actual %h %h %b",
						$time, resp.left_color, resp.right_color, resp.pixels_valid);
					mismatches++;
				end else begin
					want = owed_pixels.pop_front();
					if (resp.left_color !== want.left)
						flag("left_color", want.left, resp.left_color);
					if (resp.right_color !== want.right)
						flag("right_color", want.right, resp.right_color);
					if (resp.pixels_valid !== want.shown)
						flag("pixels_valid", {7'd0, want.shown}, {7'd0, resp.pixels_valid});
				end
			end

			// Advance the line copy on each accepted request
			if (req.valid && req.ready) begin
				case (req.req_type)
					slb_pkg::REQ_CLEAR:
						foreach (line_model[i])
							line_model[i] = '0;
					slb_pkg::REQ_START: begin
						draw_pos = req.position;
						draw_pal = req.palette_number;
						draw_two = req.write_mode;
					end
					slb_pkg::REQ_STORE:
						store_graphic(req.graphic_byte, req.fetch_address, req.holey_8,
							req.holey_16);
					slb_pkg::REQ_READ:
						owed_pixels.push_back(predict_pixels(req.cell_index));
					slb_pkg::REQ_COLOUR:
						colour_model[req.color_index] = req.color_value;
					default: ;
				endcase
			end
			outstanding = owed_pixels.size();
		end
	end
endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the scanline line buffer: a short directed run over line
// ends, position wrap, holey fetches and reads past the line, then eight
// phases of random object drawing under every read mode, both kangaroo
// settings and four patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb;

	localparam int HALF_PERIOD = 5;
	localparam int RUN_LIMIT   = 2_000_000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 125;
	localparam int SETTLE      = 8;

	localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

	typedef struct {
		logic [2:0]  kind;
		logic [7:0]  position;
		logic [2:0]  palette;
		logic        two_cells;
		logic [7:0]  data;
		logic [15:0] addr;
		logic        h8;
		logic        h16;
		logic [7:0]  cell_idx;
		logic [4:0]  cidx;
		logic [7:0]  cval;
	} line_req_t;

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle;
	int   recv_stall;
	int   pix_errors;
	int   pix_owed;

	// Per-phase register settings
	logic       phase_kang [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
	logic [1:0] phase_mode [PHASES] = '{slb_pkg::RM_WIDE, slb_pkg::RM_HIRES_B,
		slb_pkg::RM_HIRES_A, slb_pkg::RM_NONE, slb_pkg::RM_WIDE, slb_pkg::RM_HIRES_B,
		slb_pkg::RM_HIRES_A, slb_pkg::RM_NONE};

	slb_req_if  req_ch ();
	slb_resp_if resp_ch ();
	slb_cfg_if  cfg_ch ();

	scanline_line_buffer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.resp   (resp_ch),
		.cfg    (cfg_ch)
	);

	slb_pixel_checker pixel_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.resp        (resp_ch),
		.cfg         (cfg_ch),
		.mismatches  (pix_errors),
		.outstanding (pix_owed)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Stall the receiver at random
	initial begin
		resp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			resp_ch.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	initial begin
		#(RUN_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// Fill every field at random, then set the kind
	function automatic line_req_t noise_req(input logic [2:0] kind);
		line_req_t r;
		r.kind      = kind;
		r.position  = 8'($urandom);
		r.palette   = 3'($urandom);
		r.two_cells = 1'($urandom);
		r.data      = 8'($urandom);
		r.addr      = 16'($urandom);
		r.h8        = 1'($urandom);
		r.h16       = 1'($urandom);
		r.cell_idx  = 8'($urandom);
		r.cidx      = 5'($urandom);
		r.cval      = 8'($urandom);
		return r;
	endfunction

	// Offer one item after a random idle stretch, hold it until taken
	task automatic push_req(input line_req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.req_type       <= r.kind;
		req_ch.position       <= r.position;
		req_ch.palette_number <= r.palette;
		req_ch.write_mode     <= r.two_cells;
		req_ch.graphic_byte   <= r.data;
		req_ch.fetch_address  <= r.addr;
		req_ch.holey_8        <= r.h8;
		req_ch.holey_16       <= r.h16;
		req_ch.cell_index     <= r.cell_idx;
		req_ch.color_index    <= r.cidx;
		req_ch.color_value    <= r.cval;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_start(input logic [7:0] pos, input logic [2:0] pal, input logic two);
		line_req_t r;
		r = noise_req(slb_pkg::REQ_START);
		r.position  = pos;
		r.palette   = pal;
		r.two_cells = two;
		push_req(r);
	endtask

	task automatic send_store(input logic [7:0] data, input logic [15:0] addr,
			input logic h8, input logic h16);
		line_req_t r;
		r = noise_req(slb_pkg::REQ_STORE);
		r.data = data;
		r.addr = addr;
		r.h8   = h8;
		r.h16  = h16;
		push_req(r);
	endtask

	task automatic send_read(input logic [7:0] cell_idx);
		line_req_t r;
		r = noise_req(slb_pkg::REQ_READ);
		r.cell_idx = cell_idx;
		push_req(r);
	endtask

	task automatic send_colour(input logic [4:0] idx, input logic [7:0] val);
		line_req_t r;
		r = noise_req(slb_pkg::REQ_COLOUR);
		r.cidx = idx;
		r.cval = val;
		push_req(r);
	endtask

	task automatic write_reg(input logic [slb_pkg::CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.reg_index  <= idx;
		cfg_ch.write_data <= val[slb_pkg::CFG_DAT_W-1:0];
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Drop valid, wait for every owed pixel item, then let the pipe settle
	task automatic drain;
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pix_owed != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Start positions lean on the line end and the wrap
	function automatic logic [7:0] pick_position;
		case ($urandom_range(3))
			0:       return 8'($urandom_range(slb_pkg::LINE_CELLS - 1,
				slb_pkg::LINE_CELLS - 8));
			1:       return 8'($urandom);
			default: return 8'($urandom_range(slb_pkg::LINE_CELLS - 1));
		endcase
	endfunction

	// Mostly objects drawn byte by byte, with reads, colours and a little noise
	task automatic random_items(input int count);
		int sent;
		int burst;
		int pick;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_colour(5'($urandom), 8'($urandom));
				sent++;
			end else if (pick < 22) begin
				send_start(pick_position(), 3'($urandom), 1'($urandom));
				burst = $urandom_range(6, 1);
				repeat (burst)
					send_store(8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
				sent += burst + 1;
			end else if (pick < 55) begin
				send_store(8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
				sent++;
			end else if (pick < 95) begin
				if ($urandom_range(19) == 0)
					send_read(8'($urandom_range(255, slb_pkg::LINE_CELLS)));
				else
					send_read(8'($urandom_range(slb_pkg::LINE_CELLS - 1)));
				sent++;
			end else if (pick < 97) begin
				push_req(noise_req(slb_pkg::REQ_CLEAR));
				sent++;
			end else begin
				push_req(noise_req(3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST))));
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		send_idle     = 0;
		recv_stall    = 0;
		req_ch.valid  = 1'b0;
		req_ch.req_type       = slb_pkg::REQ_CLEAR;
		req_ch.position       = '0;
		req_ch.palette_number = '0;
		req_ch.write_mode     = 1'b0;
		req_ch.graphic_byte   = '0;
		req_ch.fetch_address  = '0;
		req_ch.holey_8        = 1'b0;
		req_ch.holey_16       = 1'b0;
		req_ch.cell_index     = '0;
		req_ch.color_index    = '0;
		req_ch.color_value    = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.reg_index  = slb_pkg::CFG_KANGAROO;
		cfg_ch.write_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(slb_pkg::CFG_KANGAROO, 0);
		write_reg(slb_pkg::CFG_READ_MODE, slb_pkg::RM_WIDE);

		// Colour extremes, background entry included
		send_colour(5'd0, 8'h3C);
		send_colour(5'd31, 8'hFF);
		send_colour(5'd30, 8'h00);
		// Four cells per byte, full data, then holes by bit 11 and bit 12
		send_start(8'd0, 3'd7, 1'b0);
		send_store(8'hFF, 16'h0000, 1'b0, 1'b0);
		send_store(8'h1B, 16'h8800, 1'b1, 1'b0);
		send_store(8'hE4, 16'h9000, 1'b0, 1'b1);
		// Hole bits set but below upper memory, then an all-empty byte
		send_store(8'hA5, 16'h7FFF, 1'b1, 1'b1);
		send_store(8'h00, 16'hFFFF, 1'b0, 1'b0);
		// Two cells per byte at the line end; the second byte falls off
		send_start(8'd158, 3'd5, 1'b1);
		send_store(8'hFF, 16'h1234, 1'b0, 1'b0);
		send_store(8'h3C, 16'h4321, 1'b1, 1'b1);
		// Position wraps past 255 back to the line start
		send_start(8'd254, 3'd3, 1'b0);
		send_store(8'h6C, 16'h0F0F, 1'b0, 1'b0);
		send_read(8'd0);
		send_read(8'd1);
		send_read(8'd12);
		send_read(8'd159);
		send_read(8'd160);
		send_read(8'd255);
		// Unused request kinds are ignored
		push_req(noise_req(REQ_UNUSED_FIRST));
		push_req(noise_req(REQ_UNUSED_LAST));
		push_req(noise_req(slb_pkg::REQ_CLEAR));
		send_read(8'd0);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_reg(slb_pkg::CFG_KANGAROO, phase_kang[p]);
			write_reg(slb_pkg::CFG_READ_MODE, phase_mode[p]);
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 84; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 84; end
				default: begin send_idle = 24; recv_stall = 24; end
			endcase
			random_items(PHASE_ITEMS);
		end
		drain();

		if (pix_errors == 0 && pix_owed == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
